// ----- src/psa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and helpers of the page span allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int NUM_BUCKETS = 128;
    localparam int POOL_CHUNKS = 8;

    localparam int PAGES        = 1024;
    localparam int SPACE_CHUNKS = 8;
    localparam int CHUNK_LIMIT  = (POOL_CHUNKS < SPACE_CHUNKS) ? POOL_CHUNKS : SPACE_CHUNKS;
    localparam int BKT_W        = $clog2(NUM_BUCKETS);

    localparam logic [10:0] LINK_NONE = 11'h400;
    localparam logic [6:0]  MAX_SPAN  = 7'd127;

    typedef logic [1:0]       t_action;
    typedef logic [1:0]       t_status;
    typedef logic [BKT_W-1:0] t_bkt;

    localparam t_action ACT_ALLOC  = 2'd0;
    localparam t_action ACT_FREE   = 2'd1;
    localparam t_action ACT_LOOKUP = 2'd2;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_EXHAUST = 2'd1;
    localparam t_status ST_BAD     = 2'd2;

    // Map a span length onto its free list; each 7-bit length has its own list.
    function automatic t_bkt bidx(input logic [6:0] len);
        if (int'(len) < NUM_BUCKETS) begin
            return t_bkt'(len);
        end
        return t_bkt'(NUM_BUCKETS - 1);
    endfunction

endpackage

// ----- src/psa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_req_if / psa_rsp_if
// Valid/ready channels for requests and results of the page span allocator.
// ----------------------------------------------------------------------------
interface psa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] page_count;
    logic [9:0] page_id;

    modport source (output valid, action, page_count, page_id, input ready);
    modport sink   (input valid, action, page_count, page_id, output ready);
endinterface

interface psa_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] span_start;
    logic [6:0] span_pages;
    logic       span_busy;
    logic [1:0] status;

    modport source (output valid, span_start, span_pages, span_busy, status, input ready);
    modport sink   (input valid, span_start, span_pages, span_busy, status, output ready);
endinterface

// ----- src/page_span_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_span_allocator
// Allocates, frees with coalescing, and looks up runs of pages in a
// 1024-page space, with all state held in simple dual-port style memories.
// ----------------------------------------------------------------------------
// After reset the block sweeps the page table and the free-list heads and
// takes no request meanwhile. Requests are then handled one at a time by a
// sequencer around the memories; each memory read is registered. A lookup
// reads the owner of the page, then that span's length and use bit. An
// allocate walks the free lists upward from the asked length, reading each
// list head and each span visited, then re-maps the pages of the remainder
// (up to 126) when it is split off and updates the free lists; a fresh
// chunk is mapped and listed before a second walk. A free checks each
// neighbor in turn and re-maps the pages moved by a merge. The result sits
// in an output register, so a new request is taken while it waits.
// ----------------------------------------------------------------------------
module page_span_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psa_req_if.sink      i_req,
    psa_rsp_if.source    o_rsp
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_FF_INIT, S_FF_HEAD, S_FF_HEADW, S_FF_SPAN, S_FF_SPANW,
        S_FF_NONE, S_CL_1, S_CL_2, S_CL_3, S_FOUND, S_SP_1, S_SP_2, S_SP_END,
        S_FR_CHK, S_PV_1, S_PV_2, S_PV_3, S_PV_4, S_NX_1, S_NX_2, S_NX_3, S_NX_4,
        S_FINAL, S_LK_1, S_LK_2, S_MAP, S_PU_1, S_PU_2, S_PU_3, S_DONE
    } t_state;

    t_state r_state, r_ret;

    // memories
    logic [10:0] m_own [psa_pkg::PAGES];
    logic [6:0]  m_len [psa_pkg::PAGES];
    logic        m_use [psa_pkg::PAGES];
    logic [10:0] m_nxt [psa_pkg::PAGES];
    logic [10:0] m_prv [psa_pkg::PAGES];
    logic [10:0] m_bkt [psa_pkg::NUM_BUCKETS];

    logic [9:0]  own_ra, spn_ra;
    psa_pkg::t_bkt bkt_ra;
    logic [10:0] own_rd, nxt_rd, prv_rd, bkt_rd;
    logic [6:0]  len_rd;
    logic        use_rd;

    logic        own_we, len_we, use_we, nxt_we, prv_we, bkt_we;
    logic [9:0]  own_wa, len_wa, use_wa, nxt_wa, prv_wa;
    psa_pkg::t_bkt bkt_wa;
    logic [10:0] own_wd, nxt_wd, prv_wd, bkt_wd;
    logic [6:0]  len_wd;
    logic        use_wd;

    // sequencer registers
    logic [9:0]  r_clr;
    logic [1:0]  r_act;
    logic [6:0]  r_n;
    logic [9:0]  r_pg;
    psa_pkg::t_bkt r_b;
    logic        r_pass;
    logic [3:0]  r_chunks;
    logic [9:0]  r_s;
    logic [6:0]  r_slen;
    logic [10:0] r_sprv, r_snxt;
    logic [9:0]  r_cur, r_nb;
    logic [6:0]  r_clen, r_olen;
    logic [9:0]  r_mstart;
    logic [6:0]  r_mlen, r_mi;
    logic [10:0] r_mown;
    logic [9:0]  r_pus;
    logic [6:0]  r_pulen;
    logic [10:0] r_h;
    logic [9:0]  r_res_start;
    logic [6:0]  r_res_pages;
    logic        r_res_busy;
    logic [1:0]  r_res_status;
    logic        r_ov;
    logic [9:0]  r_o_start;
    logic [6:0]  r_o_pages;
    logic        r_o_busy;
    logic [1:0]  r_o_status;

    // derived values
    logic        acc;
    logic [10:0] nx;
    logic [10:0] map_a;
    logic [7:0]  merge_sum;
    logic [10:0] split_r;
    logic [9:0]  chunk_base;
    logic        merge_ok;

    assign acc         = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign nx          = {1'b0, r_cur} + {4'b0, r_clen};
    assign map_a       = {1'b0, r_mstart} + {4'b0, r_mi};
    assign merge_sum   = {1'b0, len_rd} + {1'b0, r_clen};
    assign merge_ok    = !use_rd && !merge_sum[7];
    assign split_r     = {1'b0, r_s} + {4'b0, r_n};
    assign chunk_base  = {r_chunks[2:0], 7'd0};

    assign o_rsp.valid      = r_ov;
    assign o_rsp.span_start = r_o_start;
    assign o_rsp.span_pages = r_o_pages;
    assign o_rsp.span_busy  = r_o_busy;
    assign o_rsp.status     = r_o_status;

    // memory arrays
    always_ff @(posedge i_clk) begin
        if (own_we) m_own[own_wa] <= own_wd;
        if (len_we) m_len[len_wa] <= len_wd;
        if (use_we) m_use[use_wa] <= use_wd;
        if (nxt_we) m_nxt[nxt_wa] <= nxt_wd;
        if (prv_we) m_prv[prv_wa] <= prv_wd;
        if (bkt_we) m_bkt[bkt_wa] <= bkt_wd;
        own_rd <= m_own[own_ra];
        len_rd <= m_len[spn_ra];
        use_rd <= m_use[spn_ra];
        nxt_rd <= m_nxt[spn_ra];
        prv_rd <= m_prv[spn_ra];
        bkt_rd <= m_bkt[bkt_ra];
    end

    // memory port control
    always_comb begin
        logic        rem_en;
        logic [6:0]  rem_len;
        logic [10:0] rem_p, rem_n;
        rem_en  = 1'b0;
        rem_len = r_slen;
        rem_p   = r_sprv;
        rem_n   = r_snxt;
        own_ra = '0; spn_ra = '0; bkt_ra = '0;
        own_we = 1'b0; len_we = 1'b0; use_we = 1'b0;
        nxt_we = 1'b0; prv_we = 1'b0; bkt_we = 1'b0;
        own_wa = '0; len_wa = '0; use_wa = '0; nxt_wa = '0; prv_wa = '0; bkt_wa = '0;
        own_wd = '0; len_wd = '0; use_wd = 1'b0; nxt_wd = '0; prv_wd = '0; bkt_wd = '0;
        case (r_state)
            S_INIT: begin
                own_we = 1'b1;
                own_wa = r_clr;
                own_wd = psa_pkg::LINK_NONE;
                if (int'(r_clr) < psa_pkg::NUM_BUCKETS) begin
                    bkt_we = 1'b1;
                    bkt_wa = r_clr[psa_pkg::BKT_W-1:0];
                    bkt_wd = psa_pkg::LINK_NONE;
                end
            end
            S_IDLE: begin
                own_ra = i_req.page_id;
                spn_ra = i_req.page_id;
            end
            S_FF_HEAD: bkt_ra = r_b;
            S_FF_SPAN: spn_ra = r_s;
            S_CL_1: begin
                len_we = 1'b1; len_wa = chunk_base; len_wd = psa_pkg::MAX_SPAN;
                use_we = 1'b1; use_wa = chunk_base; use_wd = 1'b0;
            end
            S_FOUND: rem_en = 1'b1;
            S_SP_1: begin
                if (!split_r[10]) begin
                    len_we = 1'b1; len_wa = split_r[9:0]; len_wd = r_slen - r_n;
                    use_we = 1'b1; use_wa = split_r[9:0]; use_wd = 1'b0;
                end
            end
            S_SP_END: begin
                len_we = 1'b1; len_wa = r_s; len_wd = r_n;
                use_we = 1'b1; use_wa = r_s; use_wd = 1'b1;
            end
            S_FR_CHK: begin
                if (own_rd == {1'b0, r_pg} && use_rd) begin
                    use_we = 1'b1; use_wa = r_pg; use_wd = 1'b0;
                end
            end
            S_PV_1: own_ra = r_cur - 10'd1;
            S_PV_2, S_NX_2, S_LK_1: spn_ra = own_rd[9:0];
            S_PV_3, S_NX_3: begin
                rem_len = len_rd;
                rem_p   = prv_rd;
                rem_n   = nxt_rd;
                rem_en  = merge_ok;
            end
            S_PV_4: begin
                len_we = 1'b1; len_wa = r_nb; len_wd = r_olen + r_clen;
            end
            S_NX_1: own_ra = nx[9:0];
            S_NX_4: begin
                len_we = 1'b1; len_wa = r_cur; len_wd = r_clen + r_olen;
            end
            S_MAP: begin
                if (r_mi != r_mlen && !map_a[10]) begin
                    own_we = 1'b1; own_wa = map_a[9:0]; own_wd = r_mown;
                end
            end
            S_PU_1: bkt_ra = psa_pkg::bidx(r_pulen);
            S_PU_2: begin
                nxt_we = 1'b1; nxt_wa = r_pus; nxt_wd = bkt_rd;
                prv_we = 1'b1; prv_wa = r_pus; prv_wd = psa_pkg::LINK_NONE;
                bkt_we = 1'b1; bkt_wa = psa_pkg::bidx(r_pulen); bkt_wd = {1'b0, r_pus};
            end
            S_PU_3: begin
                if (!r_h[10]) begin
                    prv_we = 1'b1; prv_wa = r_h[9:0]; prv_wd = {1'b0, r_pus};
                end
            end
            default: ;
        endcase
        // unlink a span from its free list
        if (rem_en) begin
            if (!rem_p[10]) begin
                nxt_we = 1'b1; nxt_wa = rem_p[9:0]; nxt_wd = rem_n;
            end else begin
                bkt_we = 1'b1; bkt_wa = psa_pkg::bidx(rem_len); bkt_wd = rem_n;
            end
            if (!rem_n[10]) begin
                prv_we = 1'b1; prv_wa = rem_n[9:0]; prv_wd = rem_p;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ret    <= S_IDLE;
            r_clr    <= '0;
            r_chunks <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && o_rsp.ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_clr <= r_clr + 10'd1;
                    if (r_clr == 10'(psa_pkg::PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_act        <= i_req.action;
                        r_n          <= i_req.page_count;
                        r_pg         <= i_req.page_id;
                        r_pass       <= 1'b0;
                        r_res_start  <= '0;
                        r_res_pages  <= '0;
                        r_res_busy   <= 1'b0;
                        r_res_status <= psa_pkg::ST_BAD;
                        case (i_req.action)
                            psa_pkg::ACT_ALLOC: begin
                                r_state <= (i_req.page_count != 7'd0) ? S_FF_INIT : S_DONE;
                            end
                            psa_pkg::ACT_FREE:   r_state <= S_FR_CHK;
                            psa_pkg::ACT_LOOKUP: r_state <= S_LK_1;
                            default:             r_state <= S_DONE;
                        endcase
                    end
                end
                // first-fit walk over the free lists
                S_FF_INIT: begin
                    r_b     <= psa_pkg::bidx(r_n);
                    r_state <= S_FF_HEAD;
                end
                S_FF_HEAD: r_state <= S_FF_HEADW;
                S_FF_HEADW: begin
                    if (!bkt_rd[10]) begin
                        r_s     <= bkt_rd[9:0];
                        r_state <= S_FF_SPAN;
                    end else if (r_b == psa_pkg::t_bkt'(psa_pkg::NUM_BUCKETS - 1)) begin
                        r_state <= S_FF_NONE;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_FF_HEAD;
                    end
                end
                S_FF_SPAN: r_state <= S_FF_SPANW;
                S_FF_SPANW: begin
                    r_slen <= len_rd;
                    r_sprv <= prv_rd;
                    r_snxt <= nxt_rd;
                    if (len_rd >= r_n) begin
                        r_state <= S_FOUND;
                    end else if (!nxt_rd[10]) begin
                        r_s     <= nxt_rd[9:0];
                        r_state <= S_FF_SPAN;
                    end else if (r_b == psa_pkg::t_bkt'(psa_pkg::NUM_BUCKETS - 1)) begin
                        r_state <= S_FF_NONE;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_FF_HEAD;
                    end
                end
                S_FF_NONE: begin
                    if (!r_pass && int'(r_chunks) < psa_pkg::CHUNK_LIMIT) begin
                        r_state <= S_CL_1;
                    end else begin
                        r_res_status <= psa_pkg::ST_EXHAUST;
                        r_state      <= S_DONE;
                    end
                end
                // claim a fresh chunk, map it, list it, then search again
                S_CL_1: begin
                    r_mstart <= chunk_base;
                    r_mlen   <= psa_pkg::MAX_SPAN;
                    r_mown   <= {1'b0, chunk_base};
                    r_mi     <= '0;
                    r_ret    <= S_CL_2;
                    r_state  <= S_MAP;
                end
                S_CL_2: begin
                    r_pus   <= chunk_base;
                    r_pulen <= psa_pkg::MAX_SPAN;
                    r_ret   <= S_CL_3;
                    r_state <= S_PU_1;
                end
                S_CL_3: begin
                    r_chunks <= r_chunks + 4'd1;
                    r_pass   <= 1'b1;
                    r_state  <= S_FF_INIT;
                end
                // take the span and split off the remainder
                S_FOUND: r_state <= (r_slen > r_n) ? S_SP_1 : S_SP_END;
                S_SP_1: begin
                    if (!split_r[10]) begin
                        r_mstart <= split_r[9:0];
                        r_mlen   <= r_slen - r_n;
                        r_mown   <= split_r;
                        r_mi     <= '0;
                        r_ret    <= S_SP_2;
                        r_state  <= S_MAP;
                    end else begin
                        r_state <= S_SP_END;
                    end
                end
                S_SP_2: begin
                    r_pus   <= split_r[9:0];
                    r_pulen <= r_slen - r_n;
                    r_ret   <= S_SP_END;
                    r_state <= S_PU_1;
                end
                S_SP_END: begin
                    r_res_start  <= r_s;
                    r_res_pages  <= r_n;
                    r_res_busy   <= 1'b1;
                    r_res_status <= psa_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                // free: check, then merge backward and forward
                S_FR_CHK: begin
                    if (own_rd == {1'b0, r_pg} && use_rd) begin
                        r_cur   <= r_pg;
                        r_clen  <= len_rd;
                        r_state <= S_PV_1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PV_1: r_state <= (r_cur == 10'd0) ? S_NX_1 : S_PV_2;
                S_PV_2: begin
                    r_nb    <= own_rd[9:0];
                    r_state <= own_rd[10] ? S_NX_1 : S_PV_3;
                end
                S_PV_3: begin
                    if (merge_ok) begin
                        r_olen   <= len_rd;
                        r_mstart <= r_cur;
                        r_mlen   <= r_clen;
                        r_mown   <= {1'b0, r_nb};
                        r_mi     <= '0;
                        r_ret    <= S_PV_4;
                        r_state  <= S_MAP;
                    end else begin
                        r_state <= S_NX_1;
                    end
                end
                S_PV_4: begin
                    r_clen  <= r_olen + r_clen;
                    r_cur   <= r_nb;
                    r_state <= S_PV_1;
                end
                S_NX_1: r_state <= nx[10] ? S_FINAL : S_NX_2;
                S_NX_2: begin
                    r_nb    <= own_rd[9:0];
                    r_state <= own_rd[10] ? S_FINAL : S_NX_3;
                end
                S_NX_3: begin
                    if (merge_ok) begin
                        r_olen   <= len_rd;
                        r_mstart <= r_nb;
                        r_mlen   <= len_rd;
                        r_mown   <= {1'b0, r_cur};
                        r_mi     <= '0;
                        r_ret    <= S_NX_4;
                        r_state  <= S_MAP;
                    end else begin
                        r_state <= S_FINAL;
                    end
                end
                S_NX_4: begin
                    r_clen  <= r_clen + r_olen;
                    r_state <= S_NX_1;
                end
                S_FINAL: begin
                    r_pus        <= r_cur;
                    r_pulen      <= r_clen;
                    r_res_start  <= r_cur;
                    r_res_pages  <= r_clen;
                    r_res_busy   <= 1'b0;
                    r_res_status <= psa_pkg::ST_OK;
                    r_ret        <= S_DONE;
                    r_state      <= S_PU_1;
                end
                // lookup
                S_LK_1: r_state <= own_rd[10] ? S_DONE : S_LK_2;
                S_LK_2: begin
                    r_res_start  <= r_pg;
                    r_res_pages  <= len_rd;
                    r_res_busy   <= use_rd;
                    r_res_status <= psa_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                // page-table rewrite, one page a cycle
                S_MAP: begin
                    if (r_mi == r_mlen) begin
                        r_state <= r_ret;
                    end else begin
                        r_mi <= r_mi + 7'd1;
                    end
                end
                // push on the head of a free list
                S_PU_1: r_state <= S_PU_2;
                S_PU_2: begin
                    r_h     <= bkt_rd;
                    r_state <= S_PU_3;
                end
                S_PU_3: r_state <= r_ret;
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov       <= 1'b1;
                        r_o_start  <= r_res_start;
                        r_o_pages  <= r_res_pages;
                        r_o_busy   <= r_res_busy;
                        r_o_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // lookup result start comes from the page table
            if (r_state == S_LK_1) begin
                r_pg <= own_rd[9:0];
            end
        end
    end

endmodule

// ----- verif/tb_page_span_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_span_allocator
// Self-checking bench for the page span allocator. A short directed table
// covers errors, chunk claims, merges and pool exhaustion. A random mix of
// allocates, frees of live spans, lookups and noise follows. Every result
// is compared field by field against an in-bench model of the page table
// and the free lists, or against the value given in a directed row.
// ----------------------------------------------------------------------------
module tb_page_span_allocator;

    localparam int N_RANDOM   = 1225;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 400;
    localparam int NO_LINK    = 1024;
    localparam int CHUNK_STEP = 128;
    localparam int CHUNK_LEN  = 127;
    localparam psa_pkg::t_action ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [9:0]       start;
        logic [6:0]       pages;
        logic             busy;
        psa_pkg::t_status status;
    } t_span_result;

    typedef struct {
        psa_pkg::t_action act;
        logic [6:0]       cnt;
        logic [9:0]       pid;
        bit               typed;
        t_span_result     want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    psa_req_if req_if();
    psa_rsp_if rsp_if();

    page_span_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // ------------------------------------------------------------------
    // Model of the allocator state
    // ------------------------------------------------------------------
    int owner_of  [psa_pkg::PAGES];
    int len_of    [psa_pkg::PAGES];
    bit live_of   [psa_pkg::PAGES];
    int link_next [psa_pkg::PAGES];
    int link_prev [psa_pkg::PAGES];
    int list_head [psa_pkg::NUM_BUCKETS];
    int chunks_used;

    t_span_result span_expect_q[$];
    int           live_spans[$];   // start pages of spans currently allocated
    int           mismatches;
    int           idle_cycles;

    function automatic int bucket_of(input int len);
        return (len < psa_pkg::NUM_BUCKETS) ? len : psa_pkg::NUM_BUCKETS - 1;
    endfunction

    function automatic void list_insert(input int s);
        int b;
        int h;
        b = bucket_of(len_of[s]);
        h = list_head[b];
        link_next[s] = h;
        link_prev[s] = NO_LINK;
        if (h < psa_pkg::PAGES) link_prev[h] = s;
        list_head[b] = s;
    endfunction

    function automatic void list_unlink(input int s);
        int b;
        int p;
        int n;
        b = bucket_of(len_of[s]);
        p = link_prev[s];
        n = link_next[s];
        if (p < psa_pkg::PAGES) link_next[p] = n;
        else list_head[b] = n;
        if (n < psa_pkg::PAGES) link_prev[n] = p;
    endfunction

    function automatic void remap(input int start, input int len, input int own);
        for (int i = 0; i < len; i++)
            if (start + i < psa_pkg::PAGES) owner_of[start + i] = own;
    endfunction

    function automatic int first_fit(input int n);
        int s;
        int steps;
        for (int b = bucket_of(n); b < psa_pkg::NUM_BUCKETS; b++) begin
            s = list_head[b];
            steps = 0;
            while (s < psa_pkg::PAGES && steps < psa_pkg::PAGES) begin
                if (len_of[s] >= n) return s;
                s = link_next[s];
                steps++;
            end
        end
        return NO_LINK;
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < psa_pkg::PAGES; i++) begin
            owner_of[i] = NO_LINK;
            len_of[i] = 0;
            live_of[i] = 0;
        end
        for (int b = 0; b < psa_pkg::NUM_BUCKETS; b++) list_head[b] = NO_LINK;
        chunks_used = 0;
    endfunction

    // Apply one request to the model and return the result it gives.
    function automatic t_span_result span_apply(input psa_pkg::t_action act,
                                                input int n, input int pg);
        t_span_result r;
        int s;
        int c;
        int rem;
        int cur;
        int pv;
        int nx;
        int ns;
        r = '{start: '0, pages: '0, busy: 1'b0, status: psa_pkg::ST_BAD};
        if (act == psa_pkg::ACT_ALLOC && n != 0) begin
            s = first_fit(n);
            if (s >= psa_pkg::PAGES && chunks_used < psa_pkg::CHUNK_LIMIT) begin
                c = chunks_used * CHUNK_STEP;
                len_of[c] = CHUNK_LEN;
                live_of[c] = 0;
                remap(c, CHUNK_LEN, c);
                list_insert(c);
                chunks_used++;
                s = first_fit(n);
            end
            if (s < psa_pkg::PAGES) begin
                list_unlink(s);
                if (len_of[s] > n) begin
                    rem = s + n;
                    if (rem < psa_pkg::PAGES) begin
                        len_of[rem] = len_of[s] - n;
                        live_of[rem] = 0;
                        remap(rem, len_of[rem], rem);
                        list_insert(rem);
                    end
                    len_of[s] = n;
                end
                live_of[s] = 1;
                r = '{start: s[9:0], pages: n[6:0], busy: 1'b1, status: psa_pkg::ST_OK};
            end else begin
                r.status = psa_pkg::ST_EXHAUST;
            end
        end else if (act == psa_pkg::ACT_FREE) begin
            if (owner_of[pg] == pg && live_of[pg]) begin
                cur = pg;
                live_of[cur] = 0;
                // merge backward, then forward, capped at one full span
                while (cur > 0) begin
                    pv = owner_of[cur - 1];
                    if (pv >= psa_pkg::PAGES || live_of[pv]) break;
                    if (len_of[pv] + len_of[cur] > psa_pkg::MAX_SPAN) break;
                    list_unlink(pv);
                    remap(cur, len_of[cur], pv);
                    len_of[pv] = len_of[pv] + len_of[cur];
                    cur = pv;
                end
                forever begin
                    nx = cur + len_of[cur];
                    if (nx >= psa_pkg::PAGES) break;
                    ns = owner_of[nx];
                    if (ns >= psa_pkg::PAGES || live_of[ns]) break;
                    if (len_of[cur] + len_of[ns] > psa_pkg::MAX_SPAN) break;
                    list_unlink(ns);
                    remap(ns, len_of[ns], cur);
                    len_of[cur] = len_of[cur] + len_of[ns];
                end
                list_insert(cur);
                r = '{start: cur[9:0], pages: len_of[cur][6:0], busy: 1'b0,
                      status: psa_pkg::ST_OK};
            end
        end else if (act == psa_pkg::ACT_LOOKUP) begin
            if (owner_of[pg] < psa_pkg::PAGES) begin
                s = owner_of[pg];
                r = '{start: s[9:0], pages: len_of[s][6:0], busy: live_of[s],
                      status: psa_pkg::ST_OK};
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall on a pattern of its own, check each transfer
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern;
    int          ready_phase;

    initial begin
        rsp_if.ready = 1'b0;
        ready_pattern = 16'hFFFF;
        ready_phase = 0;
        forever begin
            @(negedge i_clk);
            if (ready_phase % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom());
                    2: ready_pattern = 16'($urandom()) | 16'($urandom());
                    default: ready_pattern = 16'h00FF;
                endcase
            end
            rsp_if.ready = ready_pattern[ready_phase % 16];
            ready_phase++;
        end
    end

    always @(posedge i_clk) begin
        t_span_result got;
        t_span_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{start: rsp_if.span_start, pages: rsp_if.span_pages,
                    busy: rsp_if.span_busy, status: rsp_if.status};
            if (span_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: start %0d pages %0d busy %0d st %0d",
                             got.start, got.pages, got.busy, got.status);
            end else begin
                want = span_expect_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result differs: start %0d/%0d pages %0d/%0d ",
                                  "busy %0d/%0d st %0d/%0d (expected/actual)"},
                                 want.start, got.start, want.pages, got.pages,
                                 want.busy, got.busy, want.status, got.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    int burst_left;

    // Drive one request in a burst/gap rhythm and model it on its transfer.
    task automatic send_request(input psa_pkg::t_action act, input logic [6:0] cnt,
                                input logic [9:0] pid, input bit typed,
                                input t_span_result typed_res);
        t_span_result r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        req_if.valid = 1'b1;
        req_if.action = act;
        req_if.page_count = cnt;
        req_if.page_id = pid;
        do @(posedge i_clk); while (!req_if.ready);
        r = span_apply(act, int'(cnt), int'(pid));
        span_expect_q.push_back(typed ? typed_res : r);
        if (r.status == psa_pkg::ST_OK && act == psa_pkg::ACT_ALLOC)
            live_spans.push_back(int'(r.start));
        if (r.status == psa_pkg::ST_OK && act == psa_pkg::ACT_FREE)
            foreach (live_spans[i])
                if (live_spans[i] == int'(pid)) begin
                    live_spans.delete(i);
                    break;
                end
        @(negedge i_clk);
    endtask

    function automatic t_span_result res(input int s, input int p, input bit b,
                                         input psa_pkg::t_status st);
        return '{start: s[9:0], pages: p[6:0], busy: b, status: st};
    endfunction

    t_stim_row directed[$];

    initial begin
        t_span_result none_res;
        int cnt;
        int pick;
        int sel;
        none_res = res(0, 0, 0, psa_pkg::ST_BAD);

        // errors on an empty pool, first chunk, merge back to a whole chunk
        directed.push_back('{psa_pkg::ACT_LOOKUP, 7'd0,   10'd0,    1, none_res});
        directed.push_back('{psa_pkg::ACT_FREE,   7'd0,   10'd0,    1, none_res});
        directed.push_back('{psa_pkg::ACT_ALLOC,  7'd0,   10'd0,    1, none_res});
        directed.push_back('{ACT_UNKNOWN,         7'd5,   10'd7,    1, none_res});
        directed.push_back('{psa_pkg::ACT_ALLOC,  7'd1,   10'd0,    1,
                             res(0, 1, 1, psa_pkg::ST_OK)});
        directed.push_back('{psa_pkg::ACT_ALLOC,  7'd127, 10'd0,    1,
                             res(128, 127, 1, psa_pkg::ST_OK)});
        directed.push_back('{psa_pkg::ACT_LOOKUP, 7'd0,   10'd5,    0, none_res});
        directed.push_back('{psa_pkg::ACT_FREE,   7'd0,   10'd0,    0, none_res});
        directed.push_back('{psa_pkg::ACT_FREE,   7'd0,   10'd0,    1, none_res});
        directed.push_back('{psa_pkg::ACT_FREE,   7'd0,   10'd5,    1, none_res});
        directed.push_back('{psa_pkg::ACT_LOOKUP, 7'd0,   10'd1023, 1, none_res});
        directed.push_back('{psa_pkg::ACT_LOOKUP, 7'd0,   10'd200,  0, none_res});
        // take every chunk, then run the pool dry
        directed.push_back('{psa_pkg::ACT_ALLOC,  7'd127, 10'd0,    1,
                             res(0, 127, 1, psa_pkg::ST_OK)});
        for (int c = 2; c < psa_pkg::CHUNK_LIMIT; c++)
            directed.push_back('{psa_pkg::ACT_ALLOC, 7'd127, 10'd0, 1,
                                 res(c * CHUNK_STEP, 127, 1, psa_pkg::ST_OK)});
        directed.push_back('{psa_pkg::ACT_ALLOC,  7'd1,   10'd0,    1,
                             res(0, 0, 0, psa_pkg::ST_EXHAUST)});
        directed.push_back('{psa_pkg::ACT_FREE,   7'd0,   10'd128,  0, none_res});
        directed.push_back('{psa_pkg::ACT_ALLOC,  7'd3,   10'd0,    0, none_res});
        directed.push_back('{psa_pkg::ACT_FREE,   7'd0,   10'd1023, 1, none_res});
        directed.push_back('{psa_pkg::ACT_LOOKUP, 7'd0,   10'd0,    0, none_res});

        burst_left = 0;
        model_reset();
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.action = psa_pkg::ACT_ALLOC;
        req_if.page_count = '0;
        req_if.page_id = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i])
            send_request(directed[i].act, directed[i].cnt, directed[i].pid,
                         directed[i].typed, directed[i].want);

        // random mix: mostly allocates and frees of live spans
        for (int k = 0; k < N_RANDOM; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                pick = $urandom_range(0, 19);
                cnt = (pick < 14) ? $urandom_range(1, 16)
                    : (pick < 19) ? $urandom_range(17, 64) : $urandom_range(65, 127);
                send_request(psa_pkg::ACT_ALLOC, 7'(cnt), 10'($urandom()), 0, none_res);
            end else if (sel < 80 && live_spans.size() > 0) begin
                pick = $urandom_range(0, live_spans.size() - 1);
                send_request(psa_pkg::ACT_FREE, 7'($urandom()), 10'(live_spans[pick]),
                             0, none_res);
            end else if (sel < 86) begin
                send_request(psa_pkg::ACT_FREE, 7'($urandom()), 10'($urandom()),
                             0, none_res);
            end else if (sel < 97) begin
                send_request(psa_pkg::ACT_LOOKUP, 7'($urandom()), 10'($urandom()),
                             0, none_res);
            end else begin
                send_request(ACT_UNKNOWN, 7'($urandom()), 10'($urandom()), 0, none_res);
            end
        end
        req_if.valid = 1'b0;

        // drain, then allow the last request time to settle
        while (span_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && span_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
